// ===== sv/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue: request and
// status codes, the command broadcast to the cell chain, default sizes.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int SPQ_CAPACITY      = 16;
	localparam int SPQ_PAYLOAD_WIDTH = 32;
	localparam int KEY_W             = 16;
	localparam int STATUS_W          = 2;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} spq_status_t;

	typedef struct packed {
		logic ins;
		logic rem;
	} spq_cmd_t;

endpackage

// ===== sv/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain. Holds one entry and on each command either
// keeps it, takes the new entry, takes the left neighbor's entry (insert
// shift) or takes the right neighbor's entry (remove shift).
// ----------------------------------------------------------------------------
module spq_cell #(
	parameter int PAYLOAD_WIDTH = spq_pkg::SPQ_PAYLOAD_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  spq_pkg::spq_cmd_t        cmd,
	input  logic [spq_pkg::KEY_W-1:0] new_key,
	input  logic [PAYLOAD_WIDTH-1:0] new_payload,
	input  logic                     left_valid,
	input  logic [spq_pkg::KEY_W-1:0] left_key,
	input  logic [PAYLOAD_WIDTH-1:0] left_payload,
	input  logic                     left_ahead,
	input  logic                     right_valid,
	input  logic [spq_pkg::KEY_W-1:0] right_key,
	input  logic [PAYLOAD_WIDTH-1:0] right_payload,
	output logic                     valid,
	output logic [spq_pkg::KEY_W-1:0] key,
	output logic [PAYLOAD_WIDTH-1:0] payload,
	output logic                     ahead
);
	import spq_pkg::*;

	logic                     valid_q;
	logic [KEY_W-1:0]         key_q;
	logic [PAYLOAD_WIDTH-1:0] payload_q;

	logic                     valid_d;
	logic [KEY_W-1:0]         key_d;
	logic [PAYLOAD_WIDTH-1:0] payload_d;

	// new entry goes ahead of this slot; equal keys keep arrival order
	assign ahead = !valid_q || (key_q < new_key);

	always_comb begin
		valid_d   = valid_q;
		key_d     = key_q;
		payload_d = payload_q;
		if (cmd.ins && ahead) begin
			if (left_ahead) begin
				valid_d   = left_valid;
				key_d     = left_key;
				payload_d = left_payload;
			end else begin
				valid_d   = 1'b1;
				key_d     = new_key;
				payload_d = new_payload;
			end
		end else if (cmd.rem) begin
			valid_d   = right_valid;
			key_d     = right_key;
			payload_d = right_payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q     <= key_d;
		payload_q <= payload_d;
	end

	assign valid   = valid_q;
	assign key     = key_q;
	assign payload = payload_q;

endmodule

// ===== sv/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded max-first priority queue built as a sorted chain of cells.
// Latency: the result of a transaction is shown the cycle after acceptance.
// Throughput: one transaction per cycle while the result side takes results;
// every cell updates in parallel from its neighbors.
// Reset clears the cell valid bits, the entry count and the result valid flag.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
	parameter int CAPACITY      = spq_pkg::SPQ_CAPACITY,
	parameter int PAYLOAD_WIDTH = spq_pkg::SPQ_PAYLOAD_WIDTH,
	parameter int CNT_W         = $clog2(CAPACITY + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic                        req_type,
	input  logic [spq_pkg::KEY_W-1:0]    key,
	input  logic [PAYLOAD_WIDTH-1:0]    payload,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic [spq_pkg::STATUS_W-1:0] status,
	output logic [spq_pkg::KEY_W-1:0]    out_key,
	output logic [PAYLOAD_WIDTH-1:0]    out_payload,
	output logic [CNT_W-1:0]            entry_count
);
	import spq_pkg::*;

	logic                     cell_valid   [CAPACITY];
	logic [KEY_W-1:0]         cell_key     [CAPACITY];
	logic [PAYLOAD_WIDTH-1:0] cell_payload [CAPACITY];
	logic                     cell_ahead   [CAPACITY];
	logic [CAPACITY-1:0]      valid_vec;

	spq_cmd_t       cmd;
	logic           accept;
	logic           full;
	logic           empty;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;

	logic             rsp_valid_q;
	spq_status_t      status_q;
	logic [KEY_W-1:0] out_key_q;
	logic [PAYLOAD_WIDTH-1:0] out_payload_q;
	logic [CNT_W-1:0] entry_count_q;

	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign empty     = (count_q == '0);

	assign cmd.ins = accept && (req_type == REQ_INSERT) && !full;
	assign cmd.rem = accept && (req_type == REQ_REMOVE) && !empty;

	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			logic                     l_valid;
			logic [KEY_W-1:0]         l_key;
			logic [PAYLOAD_WIDTH-1:0] l_payload;
			logic                     l_ahead;
			logic                     r_valid;
			logic [KEY_W-1:0]         r_key;
			logic [PAYLOAD_WIDTH-1:0] r_payload;

			if (i == 0) begin : g_head
				assign l_valid   = 1'b0;
				assign l_key     = '0;
				assign l_payload = '0;
				assign l_ahead   = 1'b0;
			end else begin : g_mid_l
				assign l_valid   = cell_valid[i-1];
				assign l_key     = cell_key[i-1];
				assign l_payload = cell_payload[i-1];
				assign l_ahead   = cell_ahead[i-1];
			end

			if (i == CAPACITY - 1) begin : g_tail
				assign r_valid   = 1'b0;
				assign r_key     = '0;
				assign r_payload = '0;
			end else begin : g_mid_r
				assign r_valid   = cell_valid[i+1];
				assign r_key     = cell_key[i+1];
				assign r_payload = cell_payload[i+1];
			end

			spq_cell #(
				.PAYLOAD_WIDTH(PAYLOAD_WIDTH)
			) u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.cmd          (cmd),
				.new_key      (key),
				.new_payload  (payload),
				.left_valid   (l_valid),
				.left_key     (l_key),
				.left_payload (l_payload),
				.left_ahead   (l_ahead),
				.right_valid  (r_valid),
				.right_key    (r_key),
				.right_payload(r_payload),
				.valid        (cell_valid[i]),
				.key          (cell_key[i]),
				.payload      (cell_payload[i]),
				.ahead        (cell_ahead[i])
			);

			assign valid_vec[i] = cell_valid[i];
		end
	endgenerate

	always_comb begin
		count_d = count_q;
		if (cmd.ins) begin
			count_d = count_q + CNT_W'(1);
		end else if (cmd.rem) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_count_q <= count_d;
			if (req_type == REQ_INSERT) begin
				status_q      <= full ? ST_FULL : ST_DONE;
				out_key_q     <= '0;
				out_payload_q <= '0;
			end else if (empty) begin
				status_q      <= ST_EMPTY;
				out_key_q     <= '0;
				out_payload_q <= '0;
			end else begin
				status_q      <= ST_DONE;
				out_key_q     <= cell_key[0];
				out_payload_q <= cell_payload[0];
			end
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign out_key     = out_key_q;
	assign out_payload = out_payload_q;
	assign entry_count = entry_count_q;

	a_count_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(count_q))
		else $error("entry count differs from occupied cells");

	a_remove_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req_type == REQ_REMOVE) && empty)
		|=> (status == ST_EMPTY) && (entry_count == '0) && (out_key == '0))
		else $error("remove from empty queue not reported");

	a_insert_full: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req_type == REQ_INSERT) && full)
		|=> (status == ST_FULL) && (entry_count == CNT_W'(CAPACITY)) && full)
		else $error("insert into full queue changed state");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (entry_count <= CNT_W'(CAPACITY)))
		else $error("entry count beyond capacity");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted priority queue. A driver feeds insert and
// remove transactions from a queue of pending requests. A shadow copy of the
// queue, kept sorted by descending key with ties in arrival order, predicts
// each result. A monitor compares every result field by field in order. The
// run steps through idle and stall patterns, including one long result stall.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;

	localparam int CAP       = SPQ_CAPACITY;
	localparam int PW        = SPQ_PAYLOAD_WIDTH;
	localparam int CNT_W     = $clog2(SPQ_CAPACITY + 1);
	localparam int HOLD_LEN  = 300;
	localparam int MAX_SHOWN = 10;

	typedef enum int {
		PH_STEADY,
		PH_HOLD,
		PH_SEND_IDLE,
		PH_RECV_STALL,
		PH_BOTH
	} phase_t;

	typedef struct packed {
		logic             kind;
		logic [KEY_W-1:0] key;
		logic [PW-1:0]    payload;
	} request_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PW-1:0]    payload;
	} entry_t;

	typedef struct packed {
		spq_status_t      status;
		logic [KEY_W-1:0] key;
		logic [PW-1:0]    payload;
		logic [CNT_W-1:0] count;
	} result_t;

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_stall;
	logic                req_type;
	logic [KEY_W-1:0]    key;
	logic [PW-1:0]       payload;
	logic                rsp_valid;
	logic                rsp_stall;
	logic [STATUS_W-1:0] status;
	logic [KEY_W-1:0]    out_key;
	logic [PW-1:0]       out_payload;
	logic [CNT_W-1:0]    entry_count;

	request_t pending_q[$];
	entry_t   ranked_q[$];
	result_t  owed_q[$];
	request_t on_bus;
	phase_t   phase;
	int       send_idle_pct;
	int       recv_stall_pct;
	int       issued_n;
	int       accepted_n;
	int       mismatch_cnt;
	int       hold_cnt;

	sorted_priority_queue dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req_type    (req_type),
		.key         (key),
		.payload     (payload),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.out_key     (out_key),
		.out_payload (out_payload),
		.entry_count (entry_count)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic void serve_request(input request_t rq);
		result_t r;
		entry_t  e;
		int      pos;
		r.status  = ST_DONE;
		r.key     = '0;
		r.payload = '0;
		if (rq.kind == REQ_INSERT) begin
			if (ranked_q.size() >= CAP) begin
				r.status = ST_FULL;
			end else begin
				pos = 0;
				while (pos < ranked_q.size() && ranked_q[pos].key >= rq.key)
					pos++;
				e.key     = rq.key;
				e.payload = rq.payload;
				ranked_q.insert(pos, e);
			end
		end else if (ranked_q.size() == 0) begin
			r.status = ST_EMPTY;
		end else begin
			e         = ranked_q.pop_front();
			r.key     = e.key;
			r.payload = e.payload;
		end
		r.count = CNT_W'(ranked_q.size());
		owed_q.push_back(r);
	endfunction

	task automatic add_request(input logic kind, input logic [KEY_W-1:0] k,
			input logic [PW-1:0] p);
		request_t rq;
		rq.kind    = kind;
		rq.key     = k;
		rq.payload = p;
		pending_q.push_back(rq);
		issued_n++;
	endtask

	task automatic add_directed();
		logic [KEY_W-1:0] keys [16];
		logic [PW-1:0]    p;
		keys = '{16'h0000, 16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 16'h0001,
			16'h7FFF, 16'h0100, 16'h00FF, 16'hFFFF, 16'h0000, 16'h1234,
			16'hFFFE, 16'h8000, 16'h4000, 16'h0080};
		add_request(REQ_REMOVE, 16'hFFFF, '1);
		for (int i = 0; i < 16; i++) begin
			if (i == 0)
				p = '0;
			else if (i == 1)
				p = '1;
			else
				p = PW'(32'hA5C3_0000 | i);
			add_request(REQ_INSERT, keys[i], p);
		end
		add_request(REQ_INSERT, 16'hFFFF, 32'hDEAD_0001);
		repeat (5) add_request(REQ_REMOVE, '0, '0);
	endtask

	task automatic add_random(input int n);
		int               left;
		int               burst;
		int               ins_pct;
		logic [KEY_W-1:0] k;
		logic [PW-1:0]    p;
		left = n;
		while (left > 0) begin
			burst = $urandom_range(8, 40);
			case ($urandom_range(0, 2))
				0: ins_pct = 80;
				1: ins_pct = 20;
				default: ins_pct = 50;
			endcase
			for (int i = 0; i < burst && left > 0; i++) begin
				case ($urandom_range(0, 9))
					0, 1, 2: k = KEY_W'($urandom_range(0, 3)) << 8;
					3:       k = $urandom_range(0, 1) ? '1 : '0;
					default: k = KEY_W'($urandom);
				endcase
				case ($urandom_range(0, 15))
					0:       p = '0;
					1:       p = '1;
					default: p = PW'($urandom);
				endcase
				add_request(($urandom_range(0, 99) < ins_pct) ? REQ_INSERT : REQ_REMOVE,
					k, p);
				left--;
			end
		end
	endtask

	task automatic run_phase(input phase_t ph, input int send_pct, input int recv_pct,
			input int n);
		phase          = ph;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		add_random(n);
		while (accepted_n < issued_n || owed_q.size() != 0)
			@(negedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin : driver
		request_t nxt;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_type  <= REQ_INSERT;
			key       <= '0;
			payload   <= '0;
		end else begin
			if (req_valid && !req_stall) begin
				serve_request(on_bus);
				accepted_n++;
			end
			if (!req_valid || !req_stall) begin
				if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					nxt       = pending_q.pop_front();
					on_bus    = nxt;
					req_valid <= 1'b1;
					req_type  <= nxt.kind;
					key       <= nxt.key;
					payload   <= nxt.payload;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			hold_cnt  <= 0;
		end else if (phase == PH_HOLD && hold_cnt < HOLD_LEN) begin
			rsp_stall <= 1'b1;
			hold_cnt  <= hold_cnt + 1;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	always @(posedge clk or negedge arst_n) begin : monitor
		result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (owed_q.size() == 0) begin
				if (mismatch_cnt < MAX_SHOWN)
					$display("%0t unexpected result: status %0d key %h payload %h count %0d",
						$realtime, status, out_key, out_payload, entry_count);
				mismatch_cnt++;
			end else begin
				want = owed_q.pop_front();
				if (status !== want.status || out_key !== want.key ||
						out_payload !== want.payload || entry_count !== want.count) begin
					if (mismatch_cnt < MAX_SHOWN)
						$display({"%0t result mismatch (expected/actual): status %0d/%0d ",
							"key %h/%h payload %h/%h count %0d/%0d"}, $realtime,
							want.status, status, want.key, out_key,
							want.payload, out_payload, want.count, entry_count);
					mismatch_cnt++;
				end
			end
		end
	end

	initial begin
		arst_n         = 1'b0;
		phase          = PH_STEADY;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		issued_n       = 0;
		accepted_n     = 0;
		mismatch_cnt   = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		add_directed();
		run_phase(PH_STEADY, 0, 0, 150);
		run_phase(PH_HOLD, 0, 0, 180);
		run_phase(PH_SEND_IDLE, 88, 0, 180);
		run_phase(PH_RECV_STALL, 0, 88, 180);
		run_phase(PH_BOTH, 15, 15, 190);
		repeat (8) @(negedge clk);
		if (mismatch_cnt == 0 && owed_q.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule
